@@ sv/bids_pkg.sv @@
// ----------------------------------------------------------------------------
// bids_pkg
// Shared types, constants and arithmetic helpers of the bilinear downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bids_pkg;

   localparam logic [16:0] FRAC_ONE = 17'h10000;
   localparam logic [12:0] DIM_MAX = 13'd4096;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TARGET_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_TARGET_HEIGHT = 2'd3;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [12:0] sw;
      logic [12:0] sh;
      logic [12:0] dw;
      logic [12:0] dh;
   } cfg_type;

   // One classified source pixel: its neighbors and the one or two
   // destination columns and rows that it completes.
   typedef struct packed {
      logic [31:0]       pix;
      logic [31:0]       left;
      logic [31:0]       above;
      logic [31:0]       uleft;
      logic              two_x;
      logic              two_y;
      logic [1:0][11:0]  xs;
      logic [1:0][15:0]  fxs;
      logic [1:0]        cs;
      logic [1:0]        xl;
      logic [1:0][11:0]  ys;
      logic [1:0][15:0]  fys;
      logic [1:0]        rs;
      logic [1:0]        yl;
   } q_entry_type;

   // Zero reads as one, and anything above the limit saturates to it.
   function automatic logic [12:0] clamp_dim(input logic [12:0] v, input logic [12:0] hi);
      logic [12:0] r;
      r = v;
      if (v == 13'd0) r = 13'd1;
      else if (v > hi) r = hi;
      return r;
   endfunction

   // Index of the right or lower neighbor of a 12.16 position.
   function automatic logic [11:0] far_index(input logic [27:0] pos, input logic [12:0] lim);
      logic [11:0] s;
      logic [12:0] sp1;
      s = pos[27:16];
      sp1 = {1'b0, s} + 13'd1;
      return (sp1 < lim) ? sp1[11:0] : s;
   endfunction

   function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [15:0] f);
      logic [16:0] fa;
      logic [24:0] pa;
      logic [24:0] pb;
      logic [24:0] s;
      fa = FRAC_ONE - {1'b0, f};
      pa = 25'(a) * 25'(fa);
      pb = 25'(b) * 25'(f);
      s = pa + pb;
      return s[23:16];
   endfunction

endpackage

`default_nettype wire

@@ sv/bids_if.sv @@
// ----------------------------------------------------------------------------
// bids_if
// Valid/ready channel interfaces for pixels in, pixels out and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bids_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_blue;
   logic [7:0] in_green;
   logic [7:0] in_red;
   logic [7:0] in_alpha;
   logic       frame_begin;
   modport source (output valid, in_blue, in_green, in_red, in_alpha, frame_begin,
                   input ready);
   modport sink (input valid, in_blue, in_green, in_red, in_alpha, frame_begin,
                 output ready);
endinterface

interface bids_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_blue;
   logic [7:0]  out_green;
   logic [7:0]  out_red;
   logic [7:0]  out_alpha;
   logic [11:0] out_col;
   logic [11:0] out_row;
   logic        run_last;
   logic        frame_end;
   modport source (output valid, out_blue, out_green, out_red, out_alpha, out_col,
                   out_row, run_last, frame_end, input ready);
   modport sink (input valid, out_blue, out_green, out_red, out_alpha, out_col,
                 out_row, run_last, frame_end, output ready);
endinterface

interface bids_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [12:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ sv/bids_div.sv @@
// ----------------------------------------------------------------------------
// bids_div
// Restoring divider for the 12.16 step sizes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bids_div
   import bids_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [27:0] dividend,
   input  logic [11:0] divisor,
   output logic        done,
   output logic [27:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [11:0] rem_ff, rem_in;
   logic [27:0] quo_ff, quo_in;
   logic [11:0] dsr_ff, dsr_in;
   logic [12:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[27]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd28;
         rem_in  = 12'd0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so twelve bits hold it.
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 12'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[26:0], 1'b1};
         end else begin
            rem_in = trial[11:0];
            quo_in = {quo_ff[26:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ sv/bids_front.sv @@
// ----------------------------------------------------------------------------
// bids_front
// Accepts source pixels, tracks position, keeps the line store and finds the
// destination samples that each pixel completes.
// ----------------------------------------------------------------------------
`default_nettype none

module bids_front
   import bids_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 4096
)
(
   input  logic         clock,
   input  logic         reset,
   bids_req_if.sink     req,
   input  cfg_type      cfg,
   output logic         q_valid,
   input  logic         q_ready,
   output q_entry_type  q_data
);

   localparam int AW = $clog2(MAX_LINE_WIDTH);
   localparam logic [12:0] LINE_CAP = 13'((MAX_LINE_WIDTH > 4096) ? 4096 : MAX_LINE_WIDTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIVX = 3'd1;
   localparam logic [2:0] ST_DIVY = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_CALC = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] pix_ff, pix_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] uleft_ff, uleft_in;
   logic [31:0] above_ff;
   logic [11:0] src_col_ff, src_col_in;
   logic [11:0] src_row_ff, src_row_in;
   logic [27:0] step_x_ff, step_x_in;
   logic [27:0] step_y_ff, step_y_in;
   logic [12:0] ndc_ff, ndc_in;
   logic [12:0] ndr_ff, ndr_in;
   logic [27:0] posx_ff, posx_in;
   logic [27:0] posy_ff, posy_in;
   logic [12:0] fsw_ff, fsw_in;
   logic [12:0] fsh_ff, fsh_in;
   logic [12:0] fdw_ff, fdw_in;
   logic [12:0] fdh_ff, fdh_in;

   logic [31:0] line_mem [MAX_LINE_WIDTH];
   logic [AW-1:0] addr;
   logic        mem_we;

   logic        accept, start;
   logic [12:0] n_sw, n_sh, n_dw, n_dh;
   logic        div_start, div_done;
   logic [27:0] div_dividend, div_quotient;
   logic [11:0] div_divisor;

   logic [12:0] x0, x1, y0, y1;
   logic [27:0] px0, px1, py0, py1;
   logic        cx0, cx1, cy0, cy1;
   logic        push, calc_go, col_last;
   q_entry_type ent;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign start     = req.frame_begin || (src_col_ff == 12'd0 && src_row_ff == 12'd0);

   assign n_sw = clamp_dim(cfg.sw, LINE_CAP);
   assign n_sh = clamp_dim(cfg.sh, DIM_MAX);
   assign n_dw = clamp_dim(cfg.dw, n_sw);
   assign n_dh = clamp_dim(cfg.dh, n_sh);

   bids_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Step = ((src - 1) << 16) / max(dst - 1, 1); x first, then y.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = {n_sw[11:0] - 12'd1, 16'd0};
      div_divisor  = (n_dw > 13'd1) ? 12'(n_dw - 13'd1) : 12'd1;
      if (state_ff == ST_IDLE) begin
         div_start = accept && start;
      end else if (state_ff == ST_DIVX) begin
         div_start    = div_done;
         div_dividend = {12'(fsh_ff - 13'd1), 16'd0};
         div_divisor  = (fdh_ff > 13'd1) ? 12'(fdh_ff - 13'd1) : 12'd1;
      end
   end

   // Classification of the current pixel.
   always_comb begin
      x0  = (src_col_ff == 12'd0) ? 13'd0 : ndc_ff;
      px0 = (src_col_ff == 12'd0) ? 28'd0 : posx_ff;
      x1  = x0 + 13'd1;
      px1 = px0 + step_x_ff;
      cx0 = (x0 < fdw_ff) && (far_index(px0, fsw_ff) == src_col_ff);
      cx1 = cx0 && (x1 < fdw_ff) && (far_index(px1, fsw_ff) == src_col_ff);
      y0  = ndr_ff;
      py0 = posy_ff;
      y1  = y0 + 13'd1;
      py1 = py0 + step_y_ff;
      cy0 = (y0 < fdh_ff) && (far_index(py0, fsh_ff) == src_row_ff);
      cy1 = cy0 && (y1 < fdh_ff) && (far_index(py1, fsh_ff) == src_row_ff);
      push = cx0 && cy0;
      col_last = ({1'b0, src_col_ff} + 13'd1) >= fsw_ff;

      ent.pix    = pix_ff;
      ent.left   = left_ff;
      ent.above  = above_ff;
      ent.uleft  = uleft_ff;
      ent.two_x  = cx1;
      ent.two_y  = cy1;
      ent.xs[0]  = x0[11:0];
      ent.xs[1]  = x1[11:0];
      ent.fxs[0] = px0[15:0];
      ent.fxs[1] = px1[15:0];
      ent.cs[0]  = (px0[27:16] == src_col_ff);
      ent.cs[1]  = (px1[27:16] == src_col_ff);
      ent.xl[0]  = (x0 == fdw_ff - 13'd1);
      ent.xl[1]  = (x1 == fdw_ff - 13'd1);
      ent.ys[0]  = y0[11:0];
      ent.ys[1]  = y1[11:0];
      ent.fys[0] = py0[15:0];
      ent.fys[1] = py1[15:0];
      ent.rs[0]  = (py0[27:16] == src_row_ff);
      ent.rs[1]  = (py1[27:16] == src_row_ff);
      ent.yl[0]  = (y0 == fdh_ff - 13'd1);
      ent.yl[1]  = (y1 == fdh_ff - 13'd1);
   end

   assign calc_go = (state_ff == ST_CALC) && (!push || q_ready);
   assign q_valid = (state_ff == ST_CALC) && push;
   assign q_data  = ent;
   assign mem_we  = calc_go;
   assign addr    = AW'(src_col_ff);

   always_comb begin
      state_in   = state_ff;
      pix_in     = pix_ff;
      left_in    = left_ff;
      uleft_in   = uleft_ff;
      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      step_x_in  = step_x_ff;
      step_y_in  = step_y_ff;
      ndc_in     = ndc_ff;
      ndr_in     = ndr_ff;
      posx_in    = posx_ff;
      posy_in    = posy_ff;
      fsw_in     = fsw_ff;
      fsh_in     = fsh_ff;
      fdw_in     = fdw_ff;
      fdh_in     = fdh_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pix_in = {req.in_alpha, req.in_red, req.in_green, req.in_blue};
               if (start) begin
                  fsw_in     = n_sw;
                  fsh_in     = n_sh;
                  fdw_in     = n_dw;
                  fdh_in     = n_dh;
                  src_col_in = 12'd0;
                  src_row_in = 12'd0;
                  ndc_in     = 13'd0;
                  ndr_in     = 13'd0;
                  posx_in    = 28'd0;
                  posy_in    = 28'd0;
                  state_in   = ST_DIVX;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               step_x_in = div_quotient;
               state_in  = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               step_y_in = div_quotient;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (calc_go) begin
               uleft_in = above_ff;
               left_in  = pix_ff;
               ndc_in   = x0 + {12'd0, cx0} + {12'd0, cx1};
               posx_in  = cx1 ? px1 + step_x_ff : (cx0 ? px1 : px0);
               if (col_last) begin
                  src_col_in = 12'd0;
                  ndr_in     = y0 + {12'd0, cy0} + {12'd0, cy1};
                  posy_in    = cy1 ? py1 + step_y_ff : (cy0 ? py1 : py0);
                  if (({1'b0, src_row_ff} + 13'd1) >= fsh_ff) src_row_in = 12'd0;
                  else src_row_in = src_row_ff + 12'd1;
               end else begin
                  src_col_in = src_col_ff + 12'd1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         left_ff    <= 32'd0;
         uleft_ff   <= 32'd0;
         src_col_ff <= 12'd0;
         src_row_ff <= 12'd0;
         step_x_ff  <= 28'd0;
         step_y_ff  <= 28'd0;
         ndc_ff     <= 13'd0;
         ndr_ff     <= 13'd0;
         posx_ff    <= 28'd0;
         posy_ff    <= 28'd0;
         fsw_ff     <= 13'd1;
         fsh_ff     <= 13'd1;
         fdw_ff     <= 13'd1;
         fdh_ff     <= 13'd1;
      end else begin
         state_ff   <= state_in;
         left_ff    <= left_in;
         uleft_ff   <= uleft_in;
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         step_x_ff  <= step_x_in;
         step_y_ff  <= step_y_in;
         ndc_ff     <= ndc_in;
         ndr_ff     <= ndr_in;
         posx_ff    <= posx_in;
         posy_ff    <= posy_in;
         fsw_ff     <= fsw_in;
         fsh_ff     <= fsh_in;
         fdw_ff     <= fdw_in;
         fdh_ff     <= fdh_in;
      end
      pix_ff <= pix_in;
   end

   // Line store: one row of the previous source line.
   always_ff @(posedge clock) begin
      if (mem_we) line_mem[addr] <= pix_ff;
      if (state_ff == ST_READ) above_ff <= line_mem[addr];
   end

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, src_col_ff} < fsw_ff))
      else $error("source column ran past the frame width");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVX || state_ff == ST_DIVY))
      else $error("divider finished outside a step computation");

   a_push_calc: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> (state_ff == ST_IDLE))
      else $error("front did not return to idle after a queue push");

endmodule

`default_nettype wire

@@ sv/bids_fifo.sv @@
// ----------------------------------------------------------------------------
// bids_fifo
// Short show-ahead queue of classified pixels between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bids_fifo
   import bids_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         push_ready,
   input  q_entry_type  push_data,
   output logic         pop_valid,
   input  logic         pop,
   output q_entry_type  pop_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   q_entry_type    slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ff, wr_in;
   logic [PW-1:0]  rd_ff, rd_in;
   logic [PW:0]    cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign push_ready = (cnt_ff != (PW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = slots_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) slots_ff[wr_ff] <= push_data;
   end

endmodule

`default_nettype wire

@@ sv/bids_back.sv @@
// ----------------------------------------------------------------------------
// bids_back
// Expands each queued pixel into its output samples and interpolates them in
// two registered stages: horizontal, then vertical.
// ----------------------------------------------------------------------------
`default_nettype none

module bids_back
   import bids_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  q_entry_type  q_data,
   output logic         q_pop,
   bids_rsp_if.source   rsp
);

   logic        ii_ff, ii_in;
   logic        jj_ff, jj_in;
   logic        s1_valid_ff, s1_valid_in;
   logic [3:0][7:0] s1_top_ff, s1_top_in;
   logic [3:0][7:0] s1_bot_ff, s1_bot_in;
   logic [15:0] s1_fy_ff;
   logic [11:0] s1_col_ff, s1_row_ff;
   logic        s1_last_ff, s1_end_ff;
   logic        s2_valid_ff, s2_valid_in;
   logic [3:0][7:0] s2_pix_ff, s2_pix_in;
   logic [11:0] s2_col_ff, s2_row_ff;
   logic        s2_last_ff, s2_end_ff;

   logic        adv, adv_s1, issue, last;
   logic [31:0] p00, p01, p10, p11;
   logic [15:0] fx, fy;
   logic        cs, rs;

   assign adv    = !s2_valid_ff || rsp.ready;
   assign adv_s1 = !s1_valid_ff || adv;
   assign issue  = q_valid && adv_s1;
   assign last   = (jj_ff == q_data.two_x) && (ii_ff == q_data.two_y);
   assign q_pop  = issue && last;

   always_comb begin
      fx  = q_data.fxs[jj_ff];
      fy  = q_data.fys[ii_ff];
      cs  = q_data.cs[jj_ff];
      rs  = q_data.rs[ii_ff];
      p11 = q_data.pix;
      p10 = cs ? q_data.pix : q_data.left;
      p01 = rs ? p11 : q_data.above;
      p00 = rs ? p10 : (cs ? q_data.above : q_data.uleft);
      for (int k = 0; k < 4; k++) begin
         s1_top_in[k] = blend8(p00[8*k +: 8], p01[8*k +: 8], fx);
         s1_bot_in[k] = blend8(p10[8*k +: 8], p11[8*k +: 8], fx);
         s2_pix_in[k] = blend8(s1_top_ff[k], s1_bot_ff[k], s1_fy_ff);
      end
      ii_in = ii_ff;
      jj_in = jj_ff;
      if (issue) begin
         if (last) begin
            ii_in = 1'b0;
            jj_in = 1'b0;
         end else if (jj_ff == q_data.two_x) begin
            ii_in = 1'b1;
            jj_in = 1'b0;
         end else begin
            jj_in = 1'b1;
         end
      end
      s1_valid_in = adv_s1 ? issue : s1_valid_ff;
      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ii_ff       <= 1'b0;
         jj_ff       <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         ii_ff       <= ii_in;
         jj_ff       <= jj_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (issue) begin
         s1_top_ff  <= s1_top_in;
         s1_bot_ff  <= s1_bot_in;
         s1_fy_ff   <= fy;
         s1_col_ff  <= q_data.xs[jj_ff];
         s1_row_ff  <= q_data.ys[ii_ff];
         s1_last_ff <= last;
         s1_end_ff  <= q_data.xl[jj_ff] && q_data.yl[ii_ff];
      end
      if (adv && s1_valid_ff) begin
         s2_pix_ff  <= s2_pix_in;
         s2_col_ff  <= s1_col_ff;
         s2_row_ff  <= s1_row_ff;
         s2_last_ff <= s1_last_ff;
         s2_end_ff  <= s1_end_ff;
      end
   end

   assign rsp.valid     = s2_valid_ff;
   assign rsp.out_blue  = s2_pix_ff[0];
   assign rsp.out_green = s2_pix_ff[1];
   assign rsp.out_red   = s2_pix_ff[2];
   assign rsp.out_alpha = s2_pix_ff[3];
   assign rsp.out_col   = s2_col_ff;
   assign rsp.out_row   = s2_row_ff;
   assign rsp.run_last  = s2_last_ff;
   assign rsp.frame_end = s2_end_ff;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.frame_end) |-> rsp.run_last)
      else $error("frame end word is not the last of its source pixel");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (ii_ff == 1'b0 && jj_ff == 1'b0))
      else $error("sample counters not cleared after an entry was retired");

endmodule

`default_nettype wire

@@ sv/bilinear_image_downscaler_core.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_downscaler_core
// Streaming BGRA bilinear downscaler with 12.16 fixed-point sample steps.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order on req_port, one word per pixel, and
// every destination pixel leaves on rsp_port as soon as its lower-right
// source neighbor has arrived, with its column and row, a run_last flag on
// the final word that a source pixel causes and a frame_end flag on the
// final word of the frame. The front end takes each source pixel through
// accept, line store read and classification before it accepts the next;
// for the first pixel of a frame it first gets both step sizes, x then y,
// from a shared restoring divider that produces one quotient bit per cycle
// and 28 quotient bits per step. The back end interpolates up to four
// output words per source pixel at one word per cycle while rsp_port is
// ready, behind a four-entry queue, so output stalls do not hold the input
// side until that queue fills. Register writes on csr_port are taken at
// any time and apply from the next frame start; sizes of zero read as one,
// targets larger than the source saturate to it.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_downscaler_core
   import bids_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 4096
)
(
   input  logic        clock,
   input  logic        reset,
   bids_req_if.sink    req_port,
   bids_rsp_if.source  rsp_port,
   bids_csr_if.sink    csr_port
);

   cfg_type     cfg_ff, cfg_in;
   logic        q_push, q_push_ready, q_pop_valid, q_pop;
   q_entry_type q_push_data, q_pop_data;

   // The register file never stalls a write.
   assign csr_port.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         case (csr_port.addr)
            CSR_SOURCE_WIDTH:  cfg_in.sw = csr_port.data;
            CSR_SOURCE_HEIGHT: cfg_in.sh = csr_port.data;
            CSR_TARGET_WIDTH:  cfg_in.dw = csr_port.data;
            CSR_TARGET_HEIGHT: cfg_in.dh = csr_port.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sw <= 13'd1920;
         cfg_ff.sh <= 13'd1080;
         cfg_ff.dw <= 13'd1920;
         cfg_ff.dh <= 13'd1080;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end owns position tracking, the line store and the divider.
   bids_front #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_port),
      .cfg     (cfg_ff),
      .q_valid (q_push),
      .q_ready (q_push_ready),
      .q_data  (q_push_data)
   );

   bids_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop        (q_pop),
      .pop_data   (q_pop_data)
   );

   // The back end turns each queued pixel into its one to four output words.
   bids_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_pop_valid),
      .q_data  (q_pop_data),
      .q_pop   (q_pop),
      .rsp     (rsp_port)
   );

endmodule

`default_nettype wire

@@ dv/bilinear_image_downscaler_core_tb.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_downscaler_core_tb
// Self-checking testbench of the streaming bilinear downscaler.
// ----------------------------------------------------------------------------
// Source pixels are driven in raster order. A behavioral model of the scaler
// predicts every output word as each pixel is accepted. The checker compares
// each received word field by field against the oldest prediction. Frame and
// target sizes are rewritten between phases while the block is idle. Sender
// gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_downscaler_core_tb
   import bids_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH = 4096;
   localparam int CYCLE_LIMIT = 1000000;
   // Worst case for the front end plus divider plus a full back-end queue.
   localparam int SETTLE_CYCLES = 200;

   typedef struct {
      bit [7:0]  blue;
      bit [7:0]  green;
      bit [7:0]  red;
      bit [7:0]  alpha;
      bit [11:0] col;
      bit [11:0] row;
      bit        run_last;
      bit        frame_end;
   } out_word_type;

   logic clock;
   logic reset;

   bids_req_if req_bus();
   bids_rsp_if rsp_bus();
   bids_csr_if csr_bus();

   bilinear_image_downscaler_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Scaler model state. Register values apply at each frame start.
   bit [12:0] reg_sw, reg_sh, reg_dw, reg_dh;
   bit [31:0] line_mem [LINE_DEPTH];
   bit [31:0] cur_col, cur_row, step_x, step_y, dst_col, dst_row, pos_x, pos_y;
   bit [31:0] left_pix, uleft_pix;
   bit [31:0] fr_sw, fr_sh, fr_dw, fr_dh;

   out_word_type pending_words[$];
   int        errors;
   int        cycle_count;
   int        idle_pct;
   int        stall_pct;

   function automatic bit [31:0] sat_dim(bit [31:0] v, bit [31:0] hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit [31:0] neighbor_index(bit [31:0] pos, bit [31:0] lim);
      bit [31:0] s;
      s = pos >> 16;
      return (s + 1 < lim) ? s + 1 : s;
   endfunction

   function automatic bit [7:0] lerp8(bit [31:0] a, bit [31:0] b, bit [31:0] f);
      bit [31:0] s;
      s = (a * (32'h10000 - f) + b * f) >> 16;
      return s[7:0];
   endfunction

   // Works out the output words caused by one accepted source pixel.
   task automatic scale_pixel(input bit [31:0] pix, input bit fb);
      bit [31:0] xs[2], pxs[2], ys[2], pys[2];
      bit [31:0] nx, ny, x, px, y, py, ci, above, fx, fy;
      bit [31:0] p00, p01, p10, p11, top, bot;
      bit [7:0]  ch[4];
      bit        row_same, col_same;
      out_word_type w;
      int        first;

      if (fb || (cur_col == 0 && cur_row == 0)) begin
         fr_sw = sat_dim(reg_sw, LINE_DEPTH);
         fr_sh = sat_dim(reg_sh, LINE_DEPTH);
         fr_dw = sat_dim(reg_dw, fr_sw);
         fr_dh = sat_dim(reg_dh, fr_sh);
         step_x = ((fr_sw - 1) << 16) / (fr_dw > 1 ? fr_dw - 1 : 1);
         step_y = ((fr_sh - 1) << 16) / (fr_dh > 1 ? fr_dh - 1 : 1);
         cur_col = 0; cur_row = 0; dst_col = 0; dst_row = 0; pos_x = 0; pos_y = 0;
      end
      if (cur_col == 0) begin
         dst_col = 0;
         pos_x = 0;
      end
      ci = (cur_col < LINE_DEPTH) ? cur_col : LINE_DEPTH - 1;
      above = line_mem[ci];

      nx = 0; x = dst_col; px = pos_x;
      while (nx < 2 && x < fr_dw && neighbor_index(px, fr_sw) == cur_col) begin
         xs[nx] = x; pxs[nx] = px; nx++; x++; px += step_x;
      end
      ny = 0; y = dst_row; py = pos_y;
      while (ny < 2 && y < fr_dh && neighbor_index(py, fr_sh) == cur_row) begin
         ys[ny] = y; pys[ny] = py; ny++; y++; py += step_y;
      end

      first = pending_words.size();
      for (int i = 0; i < ny; i++) begin
         fy = pys[i] & 32'hFFFF;
         row_same = (pys[i] >> 16) == cur_row;
         for (int j = 0; j < nx; j++) begin
            fx = pxs[j] & 32'hFFFF;
            col_same = (pxs[j] >> 16) == cur_col;
            p11 = pix;
            p10 = col_same ? pix : left_pix;
            p01 = row_same ? p11 : above;
            p00 = row_same ? p10 : (col_same ? above : uleft_pix);
            for (int k = 0; k < 4; k++) begin
               top = lerp8((p00 >> 8 * k) & 8'hFF, (p01 >> 8 * k) & 8'hFF, fx);
               bot = lerp8((p10 >> 8 * k) & 8'hFF, (p11 >> 8 * k) & 8'hFF, fx);
               ch[k] = lerp8(top, bot, fy);
            end
            w.blue = ch[0]; w.green = ch[1]; w.red = ch[2]; w.alpha = ch[3];
            w.col = xs[j][11:0];
            w.row = ys[i][11:0];
            w.run_last = 1'b0;
            w.frame_end = (ys[i] == fr_dh - 1) && (xs[j] == fr_dw - 1);
            pending_words.insert(pending_words.size(), w);
         end
      end
      // The final word caused by this pixel carries run_last.
      if (pending_words.size() > first)
         pending_words[pending_words.size() - 1].run_last = 1'b1;

      uleft_pix = above;
      left_pix = pix;
      line_mem[ci] = pix;
      dst_col = x;
      pos_x = px;
      cur_col++;
      if (cur_col >= fr_sw) begin
         cur_col = 0;
         dst_row = y;
         pos_y = py;
         cur_row++;
         if (cur_row >= fr_sh) cur_row = 0;
      end
   endtask

   // Sends one source pixel. Entered and left at a falling edge; valid stays
   // high on exit so back-to-back words need no extra assignment.
   task automatic send_pixel(input bit [31:0] pix, input bit fb);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.in_blue = pix[7:0];
      req_bus.in_green = pix[15:8];
      req_bus.in_red = pix[23:16];
      req_bus.in_alpha = pix[31:24];
      req_bus.frame_begin = fb;
      do @(posedge clock); while (!req_bus.ready);
      scale_pixel(pix, fb);
      @(negedge clock);
   endtask

   // Waits until every predicted word has arrived and the pipeline is quiet.
   task automatic drain;
      req_bus.valid = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input bit [12:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.addr = idx;
      csr_bus.data = value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_SOURCE_WIDTH: begin
            reg_sw = value;
         end
         CSR_SOURCE_HEIGHT: begin
            reg_sh = value;
         end
         CSR_TARGET_WIDTH: begin
            reg_dw = value;
         end
         default: begin
            reg_dh = value;
         end
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_sizes(input bit [12:0] sw, input bit [12:0] sh,
                            input bit [12:0] dw, input bit [12:0] dh);
      drain();
      write_reg(CSR_SOURCE_WIDTH, sw);
      write_reg(CSR_SOURCE_HEIGHT, sh);
      write_reg(CSR_TARGET_WIDTH, dw);
      write_reg(CSR_TARGET_HEIGHT, dh);
   endtask

   // Sends npix pixels of a frame; the first one carries frame_begin unless
   // the model sits at a frame boundary, where it may be left off.
   task automatic send_frame(input int npix, input bit rand_pix);
      bit [31:0] pix;
      bit        fb;
      for (int n = 0; n < npix; n++) begin
         pix = rand_pix ? $urandom : ((n % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
         fb = (n == 0) ? ((cur_col == 0 && cur_row == 0) ? $urandom_range(1) : 1'b1)
                       : 1'b0;
         send_pixel(pix, fb);
      end
   endtask

   function automatic int frame_pixels;
      return sat_dim(reg_sw, LINE_DEPTH) * sat_dim(reg_sh, LINE_DEPTH);
   endfunction

   // Extreme pixel values, a 4x3 to 3x2 downscale, a single output pixel
   // from zero-sized targets and an upscale request that saturates.
   task automatic test_directed;
      set_sizes(13'd4, 13'd3, 13'd3, 13'd2);
      send_frame(12, 1'b0);
      set_sizes(13'd3, 13'd2, 13'd0, 13'd0);
      send_frame(6, 1'b1);
      set_sizes(13'd2, 13'd2, 13'd9, 13'd7);
      send_frame(4, 1'b1);
   endtask

   // Random small frames; now and then a frame is cut short and the next one
   // begins with frame_begin in mid-frame.
   task automatic test_random_frames(input int target_items);
      int sent;
      int npix;
      sent = 0;
      while (sent < target_items) begin
         set_sizes($urandom_range(12, 1), $urandom_range(8, 1),
                   $urandom_range(14, 0), $urandom_range(10, 0));
         repeat ($urandom_range(2, 1)) begin
            npix = frame_pixels();
            if ($urandom_range(9) == 0) npix = $urandom_range(npix, 1);
            send_frame(npix, 1'b1);
            sent += npix;
         end
      end
   endtask

   // The largest sizes: register values beyond the line store saturate.
   // Only the start of each of these frames is sent.
   task automatic test_extreme_sizes;
      set_sizes(13'd8191, 13'd1, 13'd5000, 13'd1);
      send_frame(16, 1'b1);
      set_sizes(13'd1, 13'd8191, 13'd1, 13'd4096);
      send_frame(16, 1'b1);
   endtask

   // The sender holds off mid-frame until every word has come out.
   task automatic test_pause_mid_frame;
      int npix;
      set_sizes(13'd9, 13'd6, 13'd4, 13'd3);
      npix = frame_pixels();
      send_frame(npix / 2, 1'b1);
      req_bus.valid = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      for (int n = npix / 2; n < npix; n++) send_pixel($urandom, 1'b0);
   endtask

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   // Output checker: each accepted word against the oldest prediction.
   always @(posedge clock) begin
      out_word_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected output word at col %0d row %0d",
                   rsp_bus.out_col, rsp_bus.out_row);
            errors++;
         end else begin
            w = pending_words.pop_front();
            check_field("out_blue", w.blue, rsp_bus.out_blue);
            check_field("out_green", w.green, rsp_bus.out_green);
            check_field("out_red", w.red, rsp_bus.out_red);
            check_field("out_alpha", w.alpha, rsp_bus.out_alpha);
            check_field("out_col", w.col, rsp_bus.out_col);
            check_field("out_row", w.row, rsp_bus.out_row);
            check_field("run_last", w.run_last, rsp_bus.run_last);
            check_field("frame_end", w.frame_end, rsp_bus.frame_end);
         end
      end
   end

   // Receiver back-pressure at the rate of the current phase.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      errors = 0;
      cycle_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.in_blue = '0;
      req_bus.in_green = '0;
      req_bus.in_red = '0;
      req_bus.in_alpha = '0;
      req_bus.frame_begin = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.addr = CSR_SOURCE_WIDTH;
      csr_bus.data = '0;

      // Model reset state.
      foreach (line_mem[i]) line_mem[i] = '0;
      cur_col = 0; cur_row = 0; step_x = 0; step_y = 0;
      dst_col = 0; dst_row = 0; pos_x = 0; pos_y = 0;
      left_pix = 0; uleft_pix = 0;
      fr_sw = 1; fr_sh = 1; fr_dw = 1; fr_dh = 1;
      reg_sw = 13'd1920; reg_sh = 13'd1080; reg_dw = 13'd1920; reg_dh = 13'd1080;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_extreme_sizes();

      // Phases: no gaps, idle sender, stalling receiver, then both.
      test_random_frames(30);
      idle_pct = 69;
      test_random_frames(30);
      idle_pct = 0;
      stall_pct = 69;
      test_random_frames(30);
      idle_pct = 13;
      stall_pct = 13;
      test_random_frames(30);
      test_pause_mid_frame();

      drain();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
